// ===== src/alm_pkg.sv =====
package alm_pkg;

  // Sample format and buffer limits
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_BUFFER  = 4096;
  localparam int MAG_W       = SAMPLE_BITS;
  localparam int COUNT_W     = $clog2(MAX_BUFFER + 1);
  localparam int SUM_W       = MAG_W + $clog2(MAX_BUFFER + 1) - 1;
  localparam int DIV_STEP_W  = $clog2(SUM_W + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_BUFFER);
  localparam logic [MAG_W-1:0]   THRESHOLD_RESET = MAG_W'(32768);

  // Opcodes; a queued job reuses them, with OP_SAMPLE meaning a finished buffer
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_ARM    = 2'd1;
  localparam logic [1:0] OP_DISARM = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // Trigger states
  localparam logic [1:0] MODE_IDLE      = 2'd0;
  localparam logic [1:0] MODE_ARMED     = 2'd1;
  localparam logic [1:0] MODE_TRIGGERED = 2'd2;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [MAG_W-1:0] sample;
    logic                    last_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [MAG_W-1:0] amplitude;
    logic [MAG_W-1:0] mean_amplitude;
    logic [MAG_W-1:0] peak;
    logic [MAG_W-1:0] mean_peak;
    logic [1:0]       trigger_state;
  } out_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [MAG_W-1:0]   max_mag;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
  } job_t;

endpackage

// ===== src/alm_front.sv =====
module alm_front
  import alm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_data,
  output logic     push,
  output job_t     push_data,
  input  logic     queue_full
);

  logic [MAG_W-1:0]   running_max;
  logic [SUM_W-1:0]   running_sum;
  logic [COUNT_W-1:0] sample_count;

  logic               accept;
  logic               is_sample;
  logic [MAG_W-1:0]   mag;
  logic [MAG_W-1:0]   max_next;
  logic [SUM_W-1:0]   sum_next;
  logic [COUNT_W-1:0] count_next;

  // Hold the input whenever the queue cannot take a job
  assign in_stall  = queue_full;
  assign accept    = in_valid && !queue_full;
  assign is_sample = (in_data.opcode == OP_SAMPLE);

  // Magnitude of a two's complement sample; the most negative one maps to 2^(N-1)
  assign mag = in_data.sample[MAG_W-1] ? MAG_W'(~in_data.sample + 1'b1)
                                       : MAG_W'(in_data.sample);

  // Fold the sample into the running buffer totals
  always_comb begin
    max_next   = (mag > running_max) ? mag : running_max;
    sum_next   = running_sum;
    count_next = sample_count;
    if (sample_count < MAX_COUNT) begin
      sum_next   = running_sum + SUM_W'(mag);
      count_next = sample_count + 1'b1;
    end
  end

  // Push buffer ends and commands in arrival order
  always_comb begin
    push              = accept && (!is_sample || in_data.last_of_buffer);
    push_data.kind    = in_data.opcode;
    push_data.max_mag = max_next;
    push_data.sum     = sum_next;
    push_data.count   = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_max  <= '0;
      running_sum  <= '0;
      sample_count <= '0;
    end else if (accept && is_sample) begin
      if (in_data.last_of_buffer) begin
        running_max  <= '0;
        running_sum  <= '0;
        sample_count <= '0;
      end else begin
        running_max  <= max_next;
        running_sum  <= sum_next;
        sample_count <= count_next;
      end
    end
  end

endmodule

// ===== src/alm_queue.sv =====
module alm_queue
  import alm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_data,
  output logic full,
  input  logic pop,
  output job_t pop_data,
  output logic empty
);

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  assign full     = (fill == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = entries[rd_ptr];

  // Store the pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

// ===== src/alm_back.sv =====
module alm_back
  import alm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [MAG_W-1:0] cfg_data,
  input  logic             queue_empty,
  input  job_t             job,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]            state;
  logic [MAG_W-1:0]      threshold;
  logic [1:0]            trigger_mode;
  logic [MAG_W-1:0]      held_peak;
  logic [MAG_W-1:0]      held_mean_peak;

  logic [MAG_W-1:0]      amp;
  logic [COUNT_W-1:0]    divisor;
  logic [COUNT_W-1:0]    rem;
  logic [SUM_W-1:0]      quo;
  logic [DIV_STEP_W-1:0] step;

  logic [COUNT_W:0]      trial;
  logic                  qbit;
  logic                  out_free;
  logic [MAG_W-1:0]      mean;
  logic [MAG_W-1:0]      peak_next;
  logic [MAG_W-1:0]      mean_peak_next;
  logic [1:0]            mode_next;

  // One restoring division step
  assign trial = {rem, quo[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, divisor});

  assign out_free = !out_valid || !out_stall;
  assign pop      = (state == ST_IDLE) && !queue_empty;
  assign mean     = quo[MAG_W-1:0];

  // Update held maxima and trigger at buffer end
  always_comb begin
    peak_next      = (amp > held_peak) ? amp : held_peak;
    mean_peak_next = (mean > held_mean_peak) ? mean : held_mean_peak;
    mode_next      = trigger_mode;
    if (trigger_mode == MODE_ARMED && peak_next > threshold) begin
      mode_next = MODE_TRIGGERED;
    end
  end

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_data;
    end
  end

  // Job sequencer: commands apply at once, buffers divide then report
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      trigger_mode   <= MODE_IDLE;
      held_peak      <= '0;
      held_mean_peak <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!queue_empty) begin
            unique case (job.kind)
              OP_SAMPLE: state          <= ST_DIV;
              OP_ARM:    trigger_mode   <= MODE_ARMED;
              OP_DISARM: trigger_mode   <= MODE_IDLE;
              OP_CLEAR: begin
                held_peak      <= '0;
                held_mean_peak <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_DIV: begin
          if (step == DIV_STEP_W'(SUM_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            held_peak      <= peak_next;
            held_mean_peak <= mean_peak_next;
            trigger_mode   <= mode_next;
            state          <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Divider datapath
  always_ff @(posedge clk) begin
    if (pop && job.kind == OP_SAMPLE) begin
      amp     <= job.max_mag;
      divisor <= job.count;
      rem     <= '0;
      quo     <= job.sum;
      step    <= '0;
    end else if (state == ST_DIV) begin
      rem  <= qbit ? COUNT_W'(trial - {1'b0, divisor}) : COUNT_W'(trial);
      quo  <= {quo[SUM_W-2:0], qbit};
      step <= step + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FIN && out_free) begin
      out_data.amplitude      <= amp;
      out_data.mean_amplitude <= mean;
      out_data.peak           <= peak_next;
      out_data.mean_peak      <= mean_peak_next;
      out_data.trigger_state  <= mode_next;
    end
  end

endmodule

// ===== src/audio_level_meter_trigger.sv =====
// Channel | Signals                       | Transaction
// --------+-------------------------------+---------------------------------------
// in      | in_valid, in_stall, in_data   | sample or command (arm/disarm/clear)
// out     | out_valid, out_stall, out_data| levels and trigger state per buffer
// cfg     | cfg_we, cfg_data              | threshold write
//
// Samples are taken one per cycle while in_stall is low; the front keeps the buffer max, sum and count.
// Each buffer end passes the back through a load from the queue, a 28-step
// one-bit-per-cycle divider for the mean, and a report state that holds while
// out_stall blocks the output register. Commands apply as they are popped.
// A 4-entry job queue lies between front and back; in_stall rises when it is full.
// rst is synchronous and clears control state; threshold resets to 32768.
module audio_level_meter_trigger
  import alm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [MAG_W-1:0] cfg_data
);

  logic push;
  job_t push_data;
  logic queue_full;
  logic queue_empty;
  logic pop;
  job_t pop_data;

  alm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .push       (push),
    .push_data  (push_data),
    .queue_full (queue_full)
  );

  alm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (queue_empty)
  );

  alm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .queue_empty (queue_empty),
    .job         (pop_data),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ===== verif/tb_audio_level_meter_trigger.sv =====
`timescale 1ns / 100ps

module tb_audio_level_meter_trigger;
  import alm_pkg::*;

  localparam int SETTLE_CYCLES  = 64;    // back end finishes queued jobs
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any transaction

  // Level meter predictor and store of expected buffer reports
  class level_scoreboard;
    logic [MAG_W-1:0]   threshold;
    logic [1:0]         trig_mode;
    logic [MAG_W-1:0]   buf_max;
    logic [SUM_W-1:0]   buf_sum;
    logic [COUNT_W-1:0] buf_count;
    logic [MAG_W-1:0]   held_amp;
    logic [MAG_W-1:0]   held_mean;
    out_item_t          expected_reports[$];
    int                 failures;
    int                 items;
    int                 reports;
    int                 fired;

    function new();
      threshold = THRESHOLD_RESET;
      trig_mode = MODE_IDLE;
      buf_max   = '0;
      buf_sum   = '0;
      buf_count = '0;
      held_amp  = '0;
      held_mean = '0;
      failures  = 0;
      items     = 0;
      reports   = 0;
      fired     = 0;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    // Advance the meter by one accepted transaction
    function void note_item(in_item_t it);
      logic [MAG_W-1:0] mag;
      out_item_t        rep;
      items++;
      case (it.opcode)
        OP_ARM: trig_mode = MODE_ARMED;
        OP_DISARM: trig_mode = MODE_IDLE;
        OP_CLEAR: begin
          held_amp  = '0;
          held_mean = '0;
        end
        default: begin
          if ($signed(it.sample) < 0) mag = MAG_W'(-int'($signed(it.sample)));
          else mag = MAG_W'(it.sample);
          if (mag > buf_max) buf_max = mag;
          // only the first MAX_BUFFER samples count toward the mean
          if (buf_count < MAX_BUFFER) begin
            buf_sum   = buf_sum + SUM_W'(mag);
            buf_count = buf_count + 1'b1;
          end
          if (it.last_of_buffer) begin
            rep.amplitude      = buf_max;
            rep.mean_amplitude = MAG_W'(buf_sum / SUM_W'(buf_count));
            if (rep.amplitude > held_amp) held_amp = rep.amplitude;
            if (rep.mean_amplitude > held_mean) held_mean = rep.mean_amplitude;
            if (trig_mode == MODE_ARMED && held_amp > threshold) trig_mode = MODE_TRIGGERED;
            rep.peak          = held_amp;
            rep.mean_peak     = held_mean;
            rep.trigger_state = trig_mode;
            expected_reports.push_back(rep);
            buf_max   = '0;
            buf_sum   = '0;
            buf_count = '0;
          end
        end
      endcase
    endfunction

    // Compare one accepted report with the oldest expectation
    function void check_report(out_item_t got);
      out_item_t exp_rep;
      if (expected_reports.size() == 0) begin
        $error("unexpected report: amplitude %0d mean %0d", got.amplitude, got.mean_amplitude);
        failures++;
        return;
      end
      exp_rep = expected_reports.pop_front();
      reports++;
      if (exp_rep.trigger_state == MODE_TRIGGERED) fired++;
      if (got.amplitude !== exp_rep.amplitude) begin
        $error("amplitude: expected %0d, got %0d", exp_rep.amplitude, got.amplitude);
        failures++;
      end
      if (got.mean_amplitude !== exp_rep.mean_amplitude) begin
        $error("mean_amplitude: expected %0d, got %0d",
               exp_rep.mean_amplitude, got.mean_amplitude);
        failures++;
      end
      if (got.peak !== exp_rep.peak) begin
        $error("peak: expected %0d, got %0d", exp_rep.peak, got.peak);
        failures++;
      end
      if (got.mean_peak !== exp_rep.mean_peak) begin
        $error("mean_peak: expected %0d, got %0d", exp_rep.mean_peak, got.mean_peak);
        failures++;
      end
      if (got.trigger_state !== exp_rep.trigger_state) begin
        $error("trigger_state: expected %0d, got %0d",
               exp_rep.trigger_state, got.trigger_state);
        failures++;
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_we;
  logic [MAG_W-1:0] cfg_data;

  level_scoreboard sb = new();

  bit sender_gaps;
  bit receiver_stalls;
  bit hold_request;
  int threshold_writes;

  audio_level_meter_trigger dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic in_item_t make_item(logic [1:0] op, logic [MAG_W-1:0] s, logic last);
    in_item_t it;
    it.opcode         = op;
    it.sample         = s;
    it.last_of_buffer = last;
    return it;
  endfunction

  // Favor the magnitude extremes and small values near zero, otherwise any 16-bit pattern
  function automatic logic [MAG_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      5: return MAG_W'($urandom_range(0, 200) - 100);
      default: return MAG_W'($urandom);
    endcase
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic push_item(in_item_t it);
    if (sender_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      in_data  <= make_item(OP_SAMPLE, MAG_W'($urandom), 1'($urandom));
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_item(it);
  endtask

  task automatic push_command(logic [1:0] op);
    push_item(make_item(op, MAG_W'($urandom), 1'($urandom)));
  endtask

  // Drop valid, wait for all reports, then let queued commands retire
  task automatic settle_back_end();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [MAG_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.threshold = value;
    threshold_writes++;
  endtask

  // Mostly complete buffers with random content, commands mixed in
  task automatic random_phase(int n_items, bit with_hold);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (with_hold && sent >= n_items / 2) begin
        // stall the receiver and keep offering short buffers to fill the queue
        with_hold    = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 24; i++) push_item(make_item(OP_SAMPLE, pick_sample(), 1'b1));
        sent += 24;
      end else if (pick < 6) begin
        push_command(OP_ARM);
        sent++;
      end else if (pick < 10) begin
        push_command(OP_DISARM);
        sent++;
      end else if (pick < 14) begin
        push_command(OP_CLEAR);
        sent++;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 40) == 0) begin
            push_command(OP_CLEAR);
            sent++;
          end
          push_item(make_item(OP_SAMPLE, pick_sample(), i == len - 1));
        end
        sent += len;
      end
    end
  endtask

  // Receiver: check reports and stall in bursts or on a long hold request
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_report(out_data);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left   = HOLD_CYCLES;
      end else if (stall_left == 0 && receiver_stalls && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("** audio_level_meter_trigger: FAILED **");
    $finish;
  end

  // Stimulus
  initial begin
    logic [MAG_W-1:0] phase_thresholds[6];
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_data  <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    sender_gaps      = 1'b0;
    receiver_stalls  = 1'b0;
    hold_request     = 1'b0;
    threshold_writes = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // threshold at reset: an armed trigger can never fire
    push_item(make_item(OP_SAMPLE, 16'h8000, 1'b1));
    push_item(make_item(OP_ARM, 16'hFFFF, 1'b1));
    push_item(make_item(OP_SAMPLE, 16'h7FFF, 1'b0));
    push_item(make_item(OP_SAMPLE, 16'h0000, 1'b0));
    push_item(make_item(OP_SAMPLE, 16'hFFFF, 1'b0));
    push_item(make_item(OP_SAMPLE, 16'h0001, 1'b1));
    push_item(make_item(OP_SAMPLE, 16'h8000, 1'b1));
    push_item(make_item(OP_CLEAR, 16'h8000, 1'b1));
    // clear in mid buffer keeps the accumulation
    push_item(make_item(OP_SAMPLE, 16'd5, 1'b0));
    push_item(make_item(OP_CLEAR, 16'h0000, 1'b0));
    push_item(make_item(OP_SAMPLE, -16'sd7, 1'b1));
    push_item(make_item(OP_DISARM, 16'h7FFF, 1'b1));
    settle_back_end();

    // zero threshold: fire on any nonzero peak, re-arm while triggered
    write_threshold(16'd0);
    push_item(make_item(OP_ARM, 16'h0000, 1'b0));
    push_item(make_item(OP_SAMPLE, 16'h0000, 1'b1));
    push_item(make_item(OP_SAMPLE, 16'h0001, 1'b1));
    push_item(make_item(OP_ARM, 16'h0000, 1'b0));
    push_item(make_item(OP_SAMPLE, 16'h0000, 1'b1));
    push_item(make_item(OP_DISARM, 16'h0000, 1'b0));
    push_item(make_item(OP_SAMPLE, 16'd3, 1'b1));
    push_item(make_item(OP_CLEAR, 16'h0000, 1'b0));
    settle_back_end();

    // threshold 32767: only the most negative sample fires
    write_threshold(16'd32767);
    push_item(make_item(OP_ARM, 16'h0000, 1'b0));
    push_item(make_item(OP_SAMPLE, 16'h7FFF, 1'b1));
    push_item(make_item(OP_SAMPLE, 16'h8000, 1'b1));

    // long buffer: the loud sample falls past the counted part
    push_item(make_item(OP_CLEAR, 16'h0000, 1'b0));
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
    for (int i = 0; i < 4200; i++) begin
      if (i == 4150) push_item(make_item(OP_SAMPLE, 16'h8000, 1'b0));
      else push_item(make_item(OP_SAMPLE, MAG_W'($urandom_range(0, 200) - 100), i == 4199));
    end
    settle_back_end();

    // random phases over several thresholds, quiet handshakes at the end
    phase_thresholds[0] = 16'd1;
    phase_thresholds[1] = MAG_W'($urandom_range(0, 32768));
    phase_thresholds[2] = 16'd32768;
    phase_thresholds[3] = 16'd0;
    phase_thresholds[4] = MAG_W'($urandom_range(0, 32768));
    phase_thresholds[5] = 16'd16384;
    for (int p = 0; p < 6; p++) begin
      write_threshold(phase_thresholds[p]);
      sender_gaps     = (p != 3) && (p != 5);
      receiver_stalls = (p != 1) && (p != 5);
      random_phase(85, p == 2);
      settle_back_end();
    end

    $display("run covered %0d transactions and %0d buffer reports, %0d with the trigger fired",
             sb.items, sb.reports, sb.fired);
    $display("threshold written %0d times, including 0, 32767 and 32768",
             threshold_writes);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("** audio_level_meter_trigger: PASSED **");
    end else begin
      $display("** audio_level_meter_trigger: FAILED **");
    end
    $finish;
  end

endmodule
